// ----- hw/rtl/bhc_pkg.sv -----
// Shared types, widths and constants of the button hold classifier.
// No dependencies; every other file of the block imports this package.
package bhc_pkg;

   // Button count; only four mask registers exist, so at most four are tracked.
   localparam int BUTTON_COUNT = 4;
   localparam int NBTN         = (BUTTON_COUNT < 4) ? BUTTON_COUNT : 4;
   localparam int MASK_COUNT   = 4;

   localparam int PIN_W       = 16;
   localparam int TIME_W      = 48;
   localparam int ELAPSED_W   = 32;
   localparam int REG_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int BTN_ID_W    = 3;
   localparam int EVT_KIND_W  = 2;

   // Thresholds are kept in microseconds: (65535 + 1) * 1000 fits in 26 bits.
   localparam int THR_W      = 26;
   localparam int US_PER_MS  = 1000;

   localparam int CNT_W = $clog2(NBTN + 1);
   localparam int IDX_W = (NBTN > 1) ? $clog2(NBTN) : 1;

   // Register reset values
   localparam logic [REG_W-1:0] MASK_A_RST     = 16'd1;
   localparam logic [REG_W-1:0] MASK_B_RST     = 16'd2;
   localparam logic [REG_W-1:0] MASK_C_RST     = 16'd4;
   localparam logic [REG_W-1:0] MASK_D_RST     = 16'd8;
   localparam logic [REG_W-1:0] SHORT_MS_RST   = 16'd25;
   localparam logic [REG_W-1:0] LONG_MS_RST    = 16'd3000;
   localparam logic [REG_W-1:0] VLONG_MS_RST   = 16'd10000;
   localparam logic [REG_W-1:0] MAX_DOWN_MS_RST = 16'd60000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MASK_A   = 3'd0,
      CSR_MASK_B   = 3'd1,
      CSR_MASK_C   = 3'd2,
      CSR_MASK_D   = 3'd3,
      CSR_SHORT    = 3'd4,
      CSR_LONG     = 3'd5,
      CSR_VLONG    = 3'd6,
      CSR_MAX_DOWN = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      BTN_UP    = 3'd0,
      BTN_DOWN  = 3'd1,
      BTN_LONG  = 3'd3,
      BTN_VLONG = 3'd4,
      BTN_MAX   = 3'd5
   } btn_state_type;

   typedef enum logic [EVT_KIND_W-1:0] {
      EVT_PRESS     = 2'd0,
      EVT_HOLD      = 2'd1,
      EVT_LONG_HOLD = 2'd2
   } evt_kind_type;

   // ms to us, optionally for ms + 1 (turns "ms > t" into "us >= (t+1)*1000").
   function automatic logic [THR_W-1:0] ms_to_us(logic [REG_W-1:0] ms, logic plus_one);
      logic [THR_W-1:0] m;
      m = THR_W'(ms) + THR_W'(plus_one);
      return THR_W'(m * THR_W'(US_PER_MS));
   endfunction

   // Configuration as seen by the evaluator: masks raw, times prescaled to us.
   typedef struct packed {
      logic [MASK_COUNT-1:0][REG_W-1:0] mask;
      logic [THR_W-1:0]                 short_us;  // (short_press_ms + 1) * 1000
      logic [THR_W-1:0]                 long_us;   // (long_hold_ms + 1) * 1000
      logic [THR_W-1:0]                 vlong_us;  // (very_long_hold_ms + 1) * 1000
      logic [THR_W-1:0]                 max_us;    // max_down_ms * 1000
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      mask:     {MASK_D_RST, MASK_C_RST, MASK_B_RST, MASK_A_RST},
      short_us: ms_to_us(SHORT_MS_RST, 1'b1),
      long_us:  ms_to_us(LONG_MS_RST, 1'b1),
      vlong_us: ms_to_us(VLONG_MS_RST, 1'b1),
      max_us:   ms_to_us(MAX_DOWN_MS_RST, 1'b0)
   };

   // One poll's results, handed from the evaluator to the output buffer.
   typedef struct packed {
      logic                                valid;
      logic                                has_event;
      logic                                poll;
      logic [CNT_W-1:0]                    count;
      logic [NBTN-1:0][BTN_ID_W-1:0]       ids;
      logic [NBTN-1:0][EVT_KIND_W-1:0]     kinds;
   } load_type;

endpackage

// ----- hw/rtl/bhc_intf.sv -----
// Channel interfaces of the button hold classifier: poll input, result output
// and register write. Depends on bhc_pkg for the field widths.
interface bhc_req_if import bhc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [PIN_W-1:0]  pin_sample;
   logic [TIME_W-1:0] now_us;

   modport source (output valid, pin_sample, now_us, input ready);
   modport sink   (input valid, pin_sample, now_us, output ready);
endinterface

interface bhc_rsp_if import bhc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  event_valid;
   logic [BTN_ID_W-1:0]   button_id;
   logic [EVT_KIND_W-1:0] event_kind;
   logic                  keep_polling;
   logic                  last_of_poll;

   modport source (output valid, event_valid, button_id, event_kind, keep_polling,
                   last_of_poll, input ready);
   modport sink   (input valid, event_valid, button_id, event_kind, keep_polling,
                   last_of_poll, output ready);
endinterface

interface bhc_csr_if import bhc_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [REG_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/bhc_csr.sv -----
// Configuration registers of the button hold classifier. Time limits are
// stored prescaled to microseconds. Depends on bhc_pkg and bhc_csr_if.
module bhc_csr import bhc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bhc_csr_if.sink   csr,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_MASK_A:   cfg_in.mask[0]  = csr.data;
            CSR_MASK_B:   cfg_in.mask[1]  = csr.data;
            CSR_MASK_C:   cfg_in.mask[2]  = csr.data;
            CSR_MASK_D:   cfg_in.mask[3]  = csr.data;
            CSR_SHORT:    cfg_in.short_us = ms_to_us(csr.data, 1'b1);
            CSR_LONG:     cfg_in.long_us  = ms_to_us(csr.data, 1'b1);
            CSR_VLONG:    cfg_in.vlong_us = ms_to_us(csr.data, 1'b1);
            CSR_MAX_DOWN: cfg_in.max_us   = ms_to_us(csr.data, 1'b0);
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/bhc_eval.sv -----
// Poll input register, per-button state and single-pass classification.
// Depends on bhc_pkg and bhc_req_if; feeds bhc_emit through load_type.
module bhc_eval import bhc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   bhc_req_if.sink  req,
   input  cfg_type  cfg,
   input  logic     can_load,
   output load_type ld
);

   logic                 in_vld_ff;
   logic [PIN_W-1:0]     pin_ff;
   logic [ELAPSED_W-1:0] now_ff;      // only the low bits enter the elapsed time
   logic                 fire;

   btn_state_type              st_ff [NBTN];
   btn_state_type              st_in [NBTN];
   logic [ELAPSED_W-1:0]       start_ff [NBTN];
   logic [ELAPSED_W-1:0]       start_in [NBTN];
   logic [NBTN-1:0]            hit;
   evt_kind_type               kind [NBTN];
   logic [NBTN-1:0]            poll_lane;

   assign fire      = in_vld_ff && can_load;
   assign req.ready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         in_vld_ff <= 1'b1;
      end else if (fire) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         pin_ff <= req.pin_sample;
         now_ff <= req.now_us[ELAPSED_W-1:0];
      end
   end

   // Per-button lanes; thresholds are compared in us against the wrapped delta.
   always_comb begin
      logic                 pressed;
      logic [ELAPSED_W-1:0] elapsed;
      logic                 under_max;
      for (int i = 0; i < NBTN; i++) begin
         pressed      = (pin_ff & cfg.mask[i]) == '0;
         elapsed      = now_ff - start_ff[i];
         under_max    = elapsed < ELAPSED_W'(cfg.max_us);
         st_in[i]     = st_ff[i];
         start_in[i]  = start_ff[i];
         hit[i]       = 1'b0;
         kind[i]      = EVT_PRESS;
         poll_lane[i] = 1'b0;
         case (st_ff[i])
            BTN_UP: begin
               if (pressed) begin
                  poll_lane[i] = 1'b1;
                  start_in[i]  = now_ff;
                  st_in[i]     = BTN_DOWN;
               end
            end
            default: begin
               if (under_max) begin
                  poll_lane[i] = 1'b1;
                  if (pressed) begin
                     if (st_ff[i] == BTN_DOWN && elapsed >= ELAPSED_W'(cfg.long_us)) begin
                        st_in[i] = BTN_LONG;
                        hit[i]   = 1'b1;
                        kind[i]  = EVT_HOLD;
                     end else if (st_ff[i] == BTN_LONG &&
                                  elapsed >= ELAPSED_W'(cfg.vlong_us)) begin
                        st_in[i] = BTN_VLONG;
                        hit[i]   = 1'b1;
                        kind[i]  = EVT_LONG_HOLD;
                     end
                  end else begin
                     // release: a press only after a hold longer than the short time
                     if (st_ff[i] == BTN_DOWN && elapsed >= ELAPSED_W'(cfg.short_us)) begin
                        hit[i] = 1'b1;
                     end
                     st_in[i] = BTN_UP;
                  end
               end else begin
                  st_in[i] = pressed ? BTN_UP : BTN_MAX;
               end
            end
         endcase
      end
   end

   // Pack events in button order.
   always_comb begin
      logic [CNT_W-1:0] n;
      n     = '0;
      ld    = '0;
      for (int i = 0; i < NBTN; i++) begin
         if (hit[i]) begin
            ld.ids[n[IDX_W-1:0]]   = BTN_ID_W'(i + 1);
            ld.kinds[n[IDX_W-1:0]] = kind[i];
            n = n + CNT_W'(1);
         end
      end
      ld.valid     = fire;
      ld.has_event = (n != '0);
      ld.poll      = |poll_lane;
      ld.count     = (n != '0) ? n : CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NBTN; i++) begin
         if (reset) begin
            st_ff[i] <= BTN_UP;
         end else if (fire) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         start_ff <= start_in;
      end
   end

endmodule

// ----- hw/rtl/bhc_emit.sv -----
// Result buffer: holds one poll's results and sends them one per transfer.
// Depends on bhc_pkg and bhc_rsp_if; loaded by bhc_eval.
module bhc_emit import bhc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  load_type  ld,
   output logic      can_load,
   bhc_rsp_if.source rsp
);

   logic                            busy_ff;
   logic                            has_ev_ff;
   logic                            poll_ff;
   logic [CNT_W-1:0]                cnt_ff;
   logic [IDX_W-1:0]                ptr_ff;
   logic [NBTN-1:0][BTN_ID_W-1:0]   ids_ff;
   logic [NBTN-1:0][EVT_KIND_W-1:0] kinds_ff;
   logic                            last;
   logic                            xfer;
   logic                            done;

   assign last     = (ptr_ff == IDX_W'(cnt_ff - CNT_W'(1)));
   assign xfer     = busy_ff && rsp.ready;
   assign done     = xfer && last;
   assign can_load = !busy_ff || done;

   assign rsp.valid        = busy_ff;
   assign rsp.event_valid  = has_ev_ff;
   assign rsp.button_id    = ids_ff[ptr_ff];
   assign rsp.event_kind   = kinds_ff[ptr_ff];
   assign rsp.keep_polling = poll_ff;
   assign rsp.last_of_poll = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ptr_ff  <= '0;
      end else begin
         if (ld.valid) begin
            busy_ff   <= 1'b1;
            ptr_ff    <= '0;
            has_ev_ff <= ld.has_event;
            poll_ff   <= ld.poll;
            cnt_ff    <= ld.count;
            ids_ff    <= ld.ids;
            kinds_ff  <= ld.kinds;
         end else if (done) begin
            busy_ff <= 1'b0;
         end else if (xfer) begin
            ptr_ff <= ptr_ff + IDX_W'(1);
         end
      end
   end

`ifndef ASSERT_OFF
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ld.valid |-> can_load)
      else $error("result buffer loaded while still holding results");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0) && (CNT_W'(ptr_ff) < cnt_ff))
      else $error("result pointer beyond poll count");

   a_no_event_single: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !has_ev_ff) |-> (cnt_ff == CNT_W'(1)))
      else $error("poll without events must give exactly one result");

   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      (xfer && !last && !ld.valid) |=> (busy_ff && ptr_ff == IDX_W'($past(ptr_ff) + 1'b1)))
      else $error("result pointer did not advance after transfer");
`endif

endmodule

// ----- hw/rtl/button_hold_classifier.sv -----
// Top level of the button hold classifier: register block, poll evaluator and
// result buffer. Depends on bhc_pkg, the channel interfaces and all bhc_ modules.
//
// Each poll (pin word plus microsecond timestamp) is classified in one pass
// for up to four buttons, each selected by its mask register and read pressed
// when all its masked pins are low. A poll lands in an input register, is
// evaluated from it, and its results are loaded into the result buffer once
// that can take them. The buffer sends one result per transfer: one result
// with event_valid 0 when nothing happened, else one per press, hold or
// long-hold event in button order, all with the same keep_polling, the final
// one flagged last_of_poll. A poll occupies the output for max(1, events)
// transfers, so polls without events go through at one per cycle while the
// output is ready, the result buffer draining one entry per transfer.
// A new poll is taken while the buffer still drains, and the buffer reloads
// in the same cycle as its final transfer.
// Time limits are held internally as microseconds, so elapsed time (the low
// 32 bits of the timestamp difference) is compared without a divider; the
// limit registers are write-only through the csr channel, which is always
// ready. Write registers only while no poll is in flight.
module button_hold_classifier import bhc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bhc_req_if.sink   req_chan,
   bhc_rsp_if.source rsp_chan,
   bhc_csr_if.sink   csr_chan
);

   cfg_type  cfg;
   load_type ld;
   logic     can_load;

   // Masks and prescaled time limits
   bhc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   // Input register, button state and classification
   bhc_eval u_eval (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .cfg      (cfg),
      .can_load (can_load),
      .ld       (ld)
   );

   // Serializes one poll's results onto the output channel
   bhc_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .ld       (ld),
      .can_load (can_load),
      .rsp      (rsp_chan)
   );

endmodule

// ----- tb/tb_button_hold_classifier.sv -----
// Self-checking testbench of button_hold_classifier: random and directed polls,
// register settings and a field-by-field check of every result transfer.
// Depends on bhc_pkg, the bhc_ channel interfaces and the block's RTL.
module tb_button_hold_classifier import bhc_pkg::*;;

   // Cycles without any transfer, while work is outstanding, before giving up.
   localparam int STALL_LIMIT  = 5000;
   // Cycles left after the last result.
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASES       = 7;
   localparam int PHASE_POLLS  = 45;
   localparam int REG_COUNT    = 8;

   typedef struct packed {
      logic [PIN_W-1:0]  pin;
      logic [TIME_W-1:0] now;
   } poll_type;

   typedef struct packed {
      logic                  ev;
      logic [BTN_ID_W-1:0]   id;
      logic [EVT_KIND_W-1:0] kind;
      logic                  poll;
      logic                  last;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bhc_req_if req_chan ();
   bhc_rsp_if rsp_chan ();
   bhc_csr_if csr_chan ();

   button_hold_classifier dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Polls waiting for the driver, and results the classifier owes us.
   poll_type   queued_polls [$];
   result_type due_results [$];

   // Our own copy of the button tracking state and of the registers.
   btn_state_type     key_state   [NBTN];
   logic [TIME_W-1:0] key_down_at [NBTN];
   logic [REG_W-1:0]  mask_reg    [MASK_COUNT];
   logic [REG_W-1:0]  short_ms, long_ms, vlong_ms, max_ms;

   // No idling on either side while this is set.
   logic steady = 1'b0;

   int mismatches   = 0;
   int polls_done   = 0;
   int results_seen = 0;
   int presses_seen = 0;
   int holds_seen   = 0;
   int longs_seen   = 0;
   int settings_run = 0;
   int stall_count  = 0;

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Classify one poll against the tracked state and queue what it must yield.
   task automatic classify_poll(input logic [PIN_W-1:0] pin, input logic [TIME_W-1:0] now);
      logic [BTN_ID_W-1:0]  ev_id   [NBTN];
      evt_kind_type         ev_kind [NBTN];
      logic [TIME_W-1:0]    span;
      logic [ELAPSED_W-1:0] held_ms;
      logic                 pressed;
      logic                 poll;
      result_type           r;
      int                   n;
      int                   i;
      n    = 0;
      poll = 1'b0;
      for (i = 0; i < NBTN; i++) begin
         // A button is down when every one of its masked pins reads low.
         pressed = (pin & mask_reg[i]) == '0;
         if (key_state[i] == BTN_UP) begin
            if (pressed) begin
               poll           = 1'b1;
               key_down_at[i] = now;
               key_state[i]   = BTN_DOWN;
            end
         end else begin
            // Only the low 32 bits of the difference count, so it wraps.
            span    = now - key_down_at[i];
            held_ms = span[ELAPSED_W-1:0] / ELAPSED_W'(US_PER_MS);
            if (held_ms < ELAPSED_W'(max_ms)) begin
               poll = 1'b1;
               if (pressed) begin
                  if (key_state[i] == BTN_DOWN && held_ms > ELAPSED_W'(long_ms)) begin
                     key_state[i] = BTN_LONG;
                     ev_id[n]     = BTN_ID_W'(i + 1);
                     ev_kind[n]   = EVT_HOLD;
                     n++;
                  end else if (key_state[i] == BTN_LONG &&
                               held_ms > ELAPSED_W'(vlong_ms)) begin
                     key_state[i] = BTN_VLONG;
                     ev_id[n]     = BTN_ID_W'(i + 1);
                     ev_kind[n]   = EVT_LONG_HOLD;
                     n++;
                  end
               end else begin
                  // Release: a press event only from plain down, past short time.
                  if (key_state[i] == BTN_DOWN && held_ms > ELAPSED_W'(short_ms)) begin
                     ev_id[n]   = BTN_ID_W'(i + 1);
                     ev_kind[n] = EVT_PRESS;
                     n++;
                  end
                  key_state[i] = BTN_UP;
               end
            end else begin
               // Held past the max: stays parked if released, restarts if not.
               key_state[i] = pressed ? BTN_UP : BTN_MAX;
            end
         end
      end
      if (n == 0) begin
         r = '{ev: 1'b0, id: '0, kind: EVT_PRESS, poll: poll, last: 1'b1};
         due_results.push_back(r);
      end else begin
         for (i = 0; i < n; i++) begin
            r = '{ev: 1'b1, id: ev_id[i], kind: ev_kind[i], poll: poll,
                  last: (i == n - 1)};
            due_results.push_back(r);
         end
      end
   endtask

   task automatic queue_poll(input logic [PIN_W-1:0] pin, input logic [TIME_W-1:0] now);
      queued_polls.push_back('{pin: pin, now: now});
   endtask

   // One register write; the model is updated at the edge of the transfer.
   task automatic write_reg(input csr_index_type idx, input logic [REG_W-1:0] val);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_SHORT:    short_ms = val;
         CSR_LONG:     long_ms  = val;
         CSR_VLONG:    vlong_ms = val;
         CSR_MAX_DOWN: max_ms   = val;
         default:      mask_reg[idx] = val;
      endcase
      csr_chan.valid <= 1'b0;
   endtask

   // Block until every queued poll went in and every owed result came out.
   task automatic wait_quiet;
      do @(negedge clock);
      while (queued_polls.size() != 0 || req_chan.valid || due_results.size() != 0);
   endtask

   // Driver: offers queued polls, idling at random, and predicts on each transfer.
   always @(posedge clock) begin
      poll_type next;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            classify_poll(req_chan.pin_sample, req_chan.now_us);
            polls_done++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (queued_polls.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
               next = queued_polls.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.pin_sample <= next.pin;
               req_chan.now_us     <= next.now;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls the result side at random and checks each transfer.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
               report_mismatch("unexpected result", {7'd0, rsp_chan.event_valid}, 8'd0);
            end else begin
               want = due_results.pop_front();
               if (rsp_chan.event_valid !== want.ev)
                  report_mismatch("event_valid", rsp_chan.event_valid, want.ev);
               if (rsp_chan.button_id !== want.id)
                  report_mismatch("button_id", rsp_chan.button_id, want.id);
               if (rsp_chan.event_kind !== want.kind)
                  report_mismatch("event_kind", rsp_chan.event_kind, want.kind);
               if (rsp_chan.keep_polling !== want.poll)
                  report_mismatch("keep_polling", rsp_chan.keep_polling, want.poll);
               if (rsp_chan.last_of_poll !== want.last)
                  report_mismatch("last_of_poll", rsp_chan.last_of_poll, want.last);
               if (want.ev) begin
                  case (evt_kind_type'(want.kind))
                     EVT_PRESS: presses_seen++;
                     EVT_HOLD:  holds_seen++;
                     default:   longs_seen++;
                  endcase
               end
            end
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= 33);
      end
   end

   // Watchdog: only counts while something is outstanding and nothing moves.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            stall_count <= 0;
         end else if (queued_polls.size() != 0 || req_chan.valid || csr_chan.valid ||
                      due_results.size() != 0) begin
            stall_count <= stall_count + 1;
            if (stall_count + 1 >= STALL_LIMIT) begin
               $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
               $display("[button_hold_classifier] ERROR");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [REG_W-1:0]  setting [REG_COUNT];
      logic              hold_intent [NBTN];
      logic [TIME_W-1:0] clock_us;
      logic [PIN_W-1:0]  pin;
      int                p, k, b, j, pick;

      // Known values on every input from time zero.
      req_chan.valid      = 1'b0;
      req_chan.pin_sample = '0;
      req_chan.now_us     = '0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = CSR_MASK_A;
      csr_chan.data       = '0;

      mask_reg[0] = MASK_A_RST;
      mask_reg[1] = MASK_B_RST;
      mask_reg[2] = MASK_C_RST;
      mask_reg[3] = MASK_D_RST;
      short_ms    = SHORT_MS_RST;
      long_ms     = LONG_MS_RST;
      vlong_ms    = VLONG_MS_RST;
      max_ms      = MAX_DOWN_MS_RST;
      for (b = 0; b < NBTN; b++) begin
         key_state[b]   = BTN_UP;
         key_down_at[b] = '0;
         hold_intent[b] = 1'b0;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed polls under the reset settings: buttons on pins 0..3.
      queue_poll(16'hFFFF, 48'd0);                      // nothing down, no polling
      queue_poll(16'hFFFE, 48'd1000);                   // first button down
      queue_poll(16'hFFFF, 48'd11000);                  // quick release: no event
      queue_poll(16'h0000, 48'd100000);                 // all four down
      queue_poll(16'h0000, 48'd3101000);                // four hold events in one poll
      queue_poll(16'hFFF0, 48'd10101000);               // four long-hold events
      queue_poll(16'hFFFF, 48'd10600000);               // release from very long hold
      queue_poll(16'hFFFD, 48'd20000000);               // second button down
      queue_poll(16'hFFFF, 48'd20026000);               // release past short: press
      queue_poll(16'hFFFC, 48'd20100000);               // first two buttons down
      queue_poll(16'hFFFB, 48'd30000000);               // third button down
      queue_poll(16'hFFFB, 48'd90000000);               // still held at max: back to up
      queue_poll(16'hFFF7, 48'd100000000);              // fourth down
      queue_poll(16'hFFFF, 48'd170000000);              // released past max: max hold
      // Max hold with wrapped elapsed time under the max: pressed, then released.
      queue_poll(16'hFFF7, 48'h1_0000_0000 + 48'd105000000);
      queue_poll(16'hFFFF, 48'h1_0000_0000 + 48'd105001000);
      // Timestamp wrapping through the top of its 48 bits.
      queue_poll(16'hFFFE, 48'hFFFF_FFFF_FFFF);
      queue_poll(16'hFFFF, 48'h0000_0000_A000);
      // Hold threshold boundary: equal gives nothing, one ms over gives a hold.
      queue_poll(16'hFFFE, 48'h0000_1000_0000);
      queue_poll(16'hFFFE, 48'h0000_1000_0000 + 48'd3000999);
      queue_poll(16'hFFFE, 48'h0000_1000_0000 + 48'd3001000);
      queue_poll(16'hFFFF, 48'h0000_1000_0000 + 48'd3002000);  // release from long hold
      wait_quiet();
      clock_us = 48'h0000_1000_0000 + 48'd3002000;

      for (p = 0; p < PHASES; p++) begin
         // Settings per phase: all zero, all ones, defaults, and short random ones.
         if (p == 0) begin
            for (j = 0; j < REG_COUNT; j++) setting[j] = '0;
         end else if (p == 1) begin
            for (j = 0; j < REG_COUNT; j++) setting[j] = '1;
         end else if (p == PHASES - 1) begin
            setting[CSR_MASK_A]   = MASK_A_RST;
            setting[CSR_MASK_B]   = MASK_B_RST;
            setting[CSR_MASK_C]   = MASK_C_RST;
            setting[CSR_MASK_D]   = MASK_D_RST;
            setting[CSR_SHORT]    = SHORT_MS_RST;
            setting[CSR_LONG]     = LONG_MS_RST;
            setting[CSR_VLONG]    = VLONG_MS_RST;
            setting[CSR_MAX_DOWN] = MAX_DOWN_MS_RST;
         end else begin
            for (j = 0; j < MASK_COUNT; j++)
               setting[j] = $urandom_range(1) ? (16'd1 << $urandom_range(15))
                                              : REG_W'($urandom);
            setting[CSR_SHORT]    = REG_W'($urandom_range(40));
            setting[CSR_LONG]     = REG_W'($urandom_range(40, 400));
            setting[CSR_VLONG]    = REG_W'($urandom_range(60, 900));
            setting[CSR_MAX_DOWN] = REG_W'($urandom_range(100, 2000));
         end
         for (j = 0; j < REG_COUNT; j++) write_reg(csr_index_type'(j), setting[j]);
         settings_run++;

         // One phase runs with both sides always willing.
         steady = (p == 3);

         for (k = 0; k < PHASE_POLLS; k++) begin
            // Buttons mostly follow a held/released intent that flips now and then.
            for (b = 0; b < NBTN; b++)
               if ($urandom_range(99) < 12) hold_intent[b] = ~hold_intent[b];
            pin = PIN_W'($urandom);
            if ($urandom_range(99) >= 20) begin
               for (b = 0; b < NBTN; b++)
                  if (!hold_intent[b]) pin = pin | (mask_reg[b] & (~mask_reg[b] + 1'b1));
               for (b = 0; b < NBTN; b++)
                  if (hold_intent[b]) pin = pin & ~mask_reg[b];
            end
            // Time steps: mostly a usual poll period, sometimes up to just past the max time,
            // long gaps, near-2^32 jumps that wrap the elapsed time, or a fresh value.
            pick = $urandom_range(99);
            if (pick < 65)
               clock_us = clock_us + TIME_W'($urandom_range(40000));
            else if (pick < 82)
               clock_us = clock_us + TIME_W'($urandom_range((int'(max_ms) + 2) * 1000));
            else if (pick < 92)
               clock_us = clock_us + TIME_W'($urandom_range(90000000));
            else if (pick < 97)
               clock_us = clock_us + 48'h1_0000_0000 - TIME_W'($urandom_range(5000000));
            else
               clock_us = TIME_W'({$urandom, $urandom});
            queue_poll(pin, clock_us);
         end
         wait_quiet();
         steady = 1'b0;
      end

      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("checked %0d results of %0d polls under %0d register settings",
               results_seen, polls_done, settings_run + 1);
      $display("events seen: %0d press, %0d hold, %0d long hold; %0d mismatches",
               presses_seen, holds_seen, longs_seen, mismatches);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("[button_hold_classifier] OK");
      end else begin
         $display("[button_hold_classifier] ERROR");
      end
      $finish;
   end

endmodule
